// ----- design/tts_pkg.sv -----
// ----------------------------------------------------------------------------
// tts_pkg: shared types and constants of the tick scheduler
// Command and status codes, memory entry layouts, controller states and the
// status bundle of the remainder unit.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package tts_pkg;

  // Default storage depths
  localparam int unsigned MaxTimersDef = 8;
  localparam int unsigned MaxTasksDef  = 8;

  // Configuration register indexes (paddr[3:2])
  localparam logic [1:0] RegTickStep    = 2'd0;
  localparam logic [1:0] RegTimersInUse = 2'd1;
  localparam logic [1:0] RegTasksInUse  = 2'd2;

  // Configuration reset values
  localparam logic [15:0] TickStepRst    = 16'd1;
  localparam logic [3:0]  TimersInUseRst = 4'd8;
  localparam logic [3:0]  TasksInUseRst  = 4'd8;

  // Number of fired bits visible at the outputs
  localparam int unsigned FiredBits = 8;

  // Restoring remainder: one dividend bit per cycle
  localparam int unsigned DivSteps = 32;

  typedef enum logic [2:0] {
    FN_TICK        = 3'd0,
    FN_START_TASK  = 3'd1,
    FN_STOP_TASK   = 3'd2,
    FN_SET_PERIOD  = 3'd3,
    FN_START_TIMER = 3'd4,
    FN_STOP_TIMER  = 3'd5,
    FN_RELOAD      = 3'd6,
    FN_READ_TIMER  = 3'd7
  } func_e;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_BAD_ID    = 2'd1,
    ST_BAD_VALUE = 2'd2
  } status_e;

  typedef enum logic [2:0] {
    S_IDLE,
    S_TICK_RD,
    S_TICK_WB,
    S_CMD_RD,
    S_CMD_EX,
    S_DIV,
    S_CMD_WB,
    S_DONE
  } state_e;

  typedef struct packed {
    logic [31:0] count;
    logic [31:0] timeout;
  } timer_ent_t;

  typedef struct packed {
    logic [31:0] period;
    logic [31:0] elapsed;
  } task_ent_t;

  typedef struct packed {
    logic done;
    logic rem_zero;
  } rem_sts_t;

endpackage

`default_nettype wire

// ----- design/tts_rem.sv -----
// ----------------------------------------------------------------------------
// tts_rem: serial remainder unit
// Restoring division of a 32-bit value by a 16-bit step, one bit per cycle;
// reports when the remainder is zero.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module tts_rem (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              start_i,
  input  wire logic [31:0]       dividend_i,
  input  wire logic [15:0]       divisor_i,
  output tts_pkg::rem_sts_t      sts_o
);

  localparam int unsigned CntW = $clog2(tts_pkg::DivSteps);

  logic            busy_q, busy_d;
  logic            done_q, done_d;
  logic [CntW-1:0] cnt_q, cnt_d;
  logic [31:0]     dvd_q, dvd_d;
  logic [15:0]     rem_q, rem_d;
  logic [15:0]     dsr_q, dsr_d;
  logic [16:0]     shifted;
  logic [16:0]     trial;

  assign shifted = {rem_q, dvd_q[31]};
  assign trial   = shifted - {1'b0, dsr_q};

  always_comb begin
    busy_d = busy_q;
    done_d = 1'b0;
    cnt_d  = cnt_q;
    dvd_d  = dvd_q;
    rem_d  = rem_q;
    dsr_d  = dsr_q;
    if (start_i) begin
      busy_d = 1'b1;
      cnt_d  = '0;
      dvd_d  = dividend_i;
      rem_d  = '0;
      dsr_d  = divisor_i;
    end else if (busy_q) begin
      dvd_d = {dvd_q[30:0], 1'b0};
      // keep the trial difference unless it went negative
      rem_d = (shifted >= {1'b0, dsr_q}) ? trial[15:0] : shifted[15:0];
      cnt_d = cnt_q + 1'b1;
      if (cnt_q == CntW'(tts_pkg::DivSteps - 1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    dvd_q <= dvd_d;
    rem_q <= rem_d;
    dsr_q <= dsr_d;
  end

  assign sts_o.done     = done_q;
  assign sts_o.rem_zero = (rem_q == '0);

endmodule

`default_nettype wire

// ----- design/tick_task_and_timer_scheduler_top.sv -----
// ----------------------------------------------------------------------------
// tick_task_and_timer_scheduler_top: tick scheduler of tasks and timers
// Timer and task entries held in two synchronous memories, updated by tick
// sweeps and single-entry commands.
// ----------------------------------------------------------------------------
// Usage:
//   Command items arrive on in_valid_i/in_ready_o (func_i, index_i,
//   new_value_i); exactly one result item per command leaves on
//   out_valid_o/out_ready_i (status_o, timer_fired_o, task_fired_o,
//   timer_count_o). tick_step, timers_in_use and tasks_in_use sit on the
//   APB port at byte addresses 0, 4 and 8; write them only while idle.
//   One item is worked on at a time; the block is ready for the next item in
//   the same cycle that the result of the last one becomes valid. A tick
//   sweeps every entry index below max(MAX_TIMERS, MAX_TASKS) through a read
//   step and a write-back step of the memories. Start, stop and read commands
//   and rejected ids pass a read step and an execute step. Set period and
//   reload run the serial remainder unit over 32 bits unless the value is
//   below the step or the step is zero. A finished result waits in the output
//   register; the next item is taken meanwhile, and the block holds its own
//   result until the register frees. Reset sets the configuration registers
//   to their reset values and clears the enables and the entry valid bits, so
//   every entry reads as zero until written; no clearing pass is needed.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module tick_task_and_timer_scheduler_top #(
  parameter int unsigned MAX_TIMERS = tts_pkg::MaxTimersDef,
  parameter int unsigned MAX_TASKS  = tts_pkg::MaxTasksDef
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  // configuration port
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [3:0]  paddr,
  input  wire logic [31:0] pwdata,
  output logic [31:0]      prdata,
  output logic             pready,
  // command channel
  input  wire logic        in_valid_i,
  output logic             in_ready_o,
  input  wire logic [2:0]  func_i,
  input  wire logic [2:0]  index_i,
  input  wire logic [31:0] new_value_i,
  // result channel
  output logic             out_valid_o,
  input  wire logic        out_ready_i,
  output logic [1:0]       status_o,
  output logic [7:0]       timer_fired_o,
  output logic [7:0]       task_fired_o,
  output logic [31:0]      timer_count_o
);

  localparam int unsigned TimerAw = (MAX_TIMERS > 1) ? $clog2(MAX_TIMERS) : 1;
  localparam int unsigned TaskAw  = (MAX_TASKS > 1) ? $clog2(MAX_TASKS) : 1;
  localparam int unsigned NumEnt  = (MAX_TIMERS > MAX_TASKS) ? MAX_TIMERS : MAX_TASKS;
  localparam int unsigned IdxW    = (NumEnt > 1) ? $clog2(NumEnt) : 1;

  // configuration
  logic [15:0] tick_step_q;
  logic [3:0]  timers_in_use_q;
  logic [3:0]  tasks_in_use_q;
  logic        cfg_we;
  logic [5:0]  act_timers;
  logic [5:0]  act_tasks;

  // control
  tts_pkg::state_e  state_q, state_d;
  tts_pkg::func_e   func_q, func_d;
  logic [2:0]       id_q, id_d;
  logic [31:0]      val_q, val_d;
  logic [IdxW-1:0]  idx_q, idx_d;
  logic [MAX_TIMERS-1:0] ten_q, ten_d;
  logic [MAX_TASKS-1:0]  ken_q, ken_d;
  logic             out_valid_q, out_valid_d;
  logic             out_free;

  // result staging and output payload
  tts_pkg::status_e status_q, status_d;
  logic [7:0]       tfired_q, tfired_d;
  logic [7:0]       kfired_q, kfired_d;
  logic [31:0]      count_q, count_d;
  logic             out_load;
  logic [1:0]       out_status_q;
  logic [7:0]       out_tfired_q;
  logic [7:0]       out_kfired_q;
  logic [31:0]      out_count_q;

  // memories
  tts_pkg::timer_ent_t tmem [MAX_TIMERS];
  tts_pkg::task_ent_t  kmem [MAX_TASKS];
  tts_pkg::timer_ent_t tmem_rdata_q, tmem_wdata, tent;
  tts_pkg::task_ent_t  kmem_rdata_q, kmem_wdata, kent;
  logic [TimerAw-1:0]  taddr;
  logic [TaskAw-1:0]   kaddr;
  logic                tmem_re, tmem_we, kmem_re, kmem_we;
  logic [MAX_TIMERS-1:0] tvld_q;
  logic [MAX_TASKS-1:0]  kvld_q;
  logic                tvld_rd_q, kvld_rd_q;

  // datapath temporaries
  logic [5:0]  idx_ext;
  logic [5:0]  id_ext;
  logic        t_in, k_in, id_ok, is_task;
  logic [31:0] t_next;
  logic [31:0] k_next;

  // remainder unit
  logic              rem_start;
  tts_pkg::rem_sts_t rem_sts;

  // --------------------------------------------------------------------------
  // Configuration port
  // --------------------------------------------------------------------------
  assign pready = 1'b1;
  assign cfg_we = psel & penable & pwrite & pready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tick_step_q     <= tts_pkg::TickStepRst;
      timers_in_use_q <= tts_pkg::TimersInUseRst;
      tasks_in_use_q  <= tts_pkg::TasksInUseRst;
    end else if (cfg_we) begin
      case (paddr[3:2])
        tts_pkg::RegTickStep:    tick_step_q     <= pwdata[15:0];
        tts_pkg::RegTimersInUse: timers_in_use_q <= pwdata[3:0];
        tts_pkg::RegTasksInUse:  tasks_in_use_q  <= pwdata[3:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (paddr[3:2])
      tts_pkg::RegTickStep:    prdata = {16'd0, tick_step_q};
      tts_pkg::RegTimersInUse: prdata = {28'd0, timers_in_use_q};
      tts_pkg::RegTasksInUse:  prdata = {28'd0, tasks_in_use_q};
      default:                 prdata = '0;
    endcase
  end

  assign act_timers = (6'(timers_in_use_q) < 6'(MAX_TIMERS)) ? 6'(timers_in_use_q)
                                                             : 6'(MAX_TIMERS);
  assign act_tasks  = (6'(tasks_in_use_q) < 6'(MAX_TASKS)) ? 6'(tasks_in_use_q)
                                                           : 6'(MAX_TASKS);

  // --------------------------------------------------------------------------
  // Entry memories; an entry never written reads as zero
  // --------------------------------------------------------------------------
  assign taddr = (state_q == tts_pkg::S_TICK_RD || state_q == tts_pkg::S_TICK_WB)
                 ? TimerAw'(idx_q) : TimerAw'(id_q);
  assign kaddr = (state_q == tts_pkg::S_TICK_RD || state_q == tts_pkg::S_TICK_WB)
                 ? TaskAw'(idx_q) : TaskAw'(id_q);

  always_ff @(posedge clk_i) begin
    if (tmem_we) tmem[taddr] <= tmem_wdata;
    if (tmem_re) tmem_rdata_q <= tmem[taddr];
  end

  always_ff @(posedge clk_i) begin
    if (kmem_we) kmem[kaddr] <= kmem_wdata;
    if (kmem_re) kmem_rdata_q <= kmem[kaddr];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tvld_q    <= '0;
      kvld_q    <= '0;
      tvld_rd_q <= 1'b0;
      kvld_rd_q <= 1'b0;
    end else begin
      if (tmem_we) tvld_q[taddr] <= 1'b1;
      if (kmem_we) kvld_q[kaddr] <= 1'b1;
      if (tmem_re) tvld_rd_q <= tvld_q[taddr];
      if (kmem_re) kvld_rd_q <= kvld_q[kaddr];
    end
  end

  assign tent = tvld_rd_q ? tmem_rdata_q : '0;
  assign kent = kvld_rd_q ? kmem_rdata_q : '0;

  // --------------------------------------------------------------------------
  // Remainder unit for the multiple-of-step test
  // --------------------------------------------------------------------------
  tts_rem u_rem (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (rem_start),
    .dividend_i (val_q),
    .divisor_i  (tick_step_q),
    .sts_o      (rem_sts)
  );

  // --------------------------------------------------------------------------
  // Controller
  // --------------------------------------------------------------------------
  assign idx_ext = 6'(idx_q);
  assign id_ext  = 6'(id_q);
  assign t_in    = idx_ext < act_timers;
  assign k_in    = idx_ext < act_tasks;
  assign is_task = (func_q == tts_pkg::FN_START_TASK) || (func_q == tts_pkg::FN_STOP_TASK) ||
                   (func_q == tts_pkg::FN_SET_PERIOD);
  assign id_ok   = is_task ? (id_ext < act_tasks) : (id_ext < act_timers);
  assign t_next  = tent.count - {16'd0, tick_step_q};
  assign k_next  = kent.elapsed + {16'd0, tick_step_q};

  assign out_free   = !out_valid_q || out_ready_i;
  assign in_ready_o = (state_q == tts_pkg::S_IDLE);

  always_comb begin
    state_d     = state_q;
    func_d      = func_q;
    id_d        = id_q;
    val_d       = val_q;
    idx_d       = idx_q;
    ten_d       = ten_q;
    ken_d       = ken_q;
    status_d    = status_q;
    tfired_d    = tfired_q;
    kfired_d    = kfired_q;
    count_d     = count_q;
    out_valid_d = out_valid_q & ~out_ready_i;
    out_load    = 1'b0;
    tmem_re     = 1'b0;
    tmem_we     = 1'b0;
    kmem_re     = 1'b0;
    kmem_we     = 1'b0;
    tmem_wdata  = tent;
    kmem_wdata  = kent;
    rem_start   = 1'b0;

    case (state_q)
      tts_pkg::S_IDLE: begin
        if (in_valid_i) begin
          func_d   = tts_pkg::func_e'(func_i);
          id_d     = index_i;
          val_d    = new_value_i;
          idx_d    = '0;
          status_d = tts_pkg::ST_OK;
          tfired_d = '0;
          kfired_d = '0;
          count_d  = '0;
          state_d  = (tts_pkg::func_e'(func_i) == tts_pkg::FN_TICK) ? tts_pkg::S_TICK_RD
                                                                    : tts_pkg::S_CMD_RD;
        end
      end

      tts_pkg::S_TICK_RD: begin
        tmem_re = 1'b1;
        kmem_re = 1'b1;
        state_d = tts_pkg::S_TICK_WB;
      end

      tts_pkg::S_TICK_WB: begin
        if (t_in && ten_q[taddr]) begin
          tmem_we    = 1'b1;
          tmem_wdata = '{count: t_next, timeout: tent.timeout};
          if (t_next == '0 && idx_ext < 6'(tts_pkg::FiredBits)) tfired_d[idx_ext[2:0]] = 1'b1;
        end
        if (k_in && ken_q[kaddr]) begin
          kmem_we = 1'b1;
          if (k_next >= kent.period) begin
            kmem_wdata = '{period: kent.period, elapsed: 32'd0};
            if (idx_ext < 6'(tts_pkg::FiredBits)) kfired_d[idx_ext[2:0]] = 1'b1;
          end else begin
            kmem_wdata = '{period: kent.period, elapsed: k_next};
          end
        end
        if (idx_q == IdxW'(NumEnt - 1)) begin
          state_d = tts_pkg::S_DONE;
        end else begin
          idx_d   = idx_q + 1'b1;
          state_d = tts_pkg::S_TICK_RD;
        end
      end

      tts_pkg::S_CMD_RD: begin
        tmem_re = 1'b1;
        kmem_re = 1'b1;
        state_d = tts_pkg::S_CMD_EX;
      end

      tts_pkg::S_CMD_EX: begin
        state_d = tts_pkg::S_DONE;
        if (!id_ok) begin
          status_d = tts_pkg::ST_BAD_ID;
        end else begin
          case (func_q)
            tts_pkg::FN_START_TASK: ken_d[kaddr] = 1'b1;
            tts_pkg::FN_STOP_TASK:  ken_d[kaddr] = 1'b0;
            tts_pkg::FN_STOP_TIMER: ten_d[taddr] = 1'b0;
            tts_pkg::FN_START_TIMER: begin
              ten_d[taddr] = 1'b1;
              tmem_we      = 1'b1;
              tmem_wdata   = '{count: (tent.count == '0) ? tent.timeout : tent.count,
                               timeout: tent.timeout};
            end
            tts_pkg::FN_READ_TIMER: count_d = tent.count;
            tts_pkg::FN_SET_PERIOD, tts_pkg::FN_RELOAD: begin
              if (val_q < {16'd0, tick_step_q}) begin
                status_d = tts_pkg::ST_BAD_VALUE;
              end else if (tick_step_q == '0) begin
                state_d = tts_pkg::S_CMD_WB;
              end else begin
                rem_start = 1'b1;
                state_d   = tts_pkg::S_DIV;
              end
            end
            default: ;
          endcase
        end
      end

      tts_pkg::S_DIV: begin
        if (rem_sts.done) begin
          if (rem_sts.rem_zero) begin
            state_d = tts_pkg::S_CMD_WB;
          end else begin
            status_d = tts_pkg::ST_BAD_VALUE;
            state_d  = tts_pkg::S_DONE;
          end
        end
      end

      tts_pkg::S_CMD_WB: begin
        // read data still holds the entry fetched in the read step
        if (func_q == tts_pkg::FN_SET_PERIOD) begin
          kmem_we    = 1'b1;
          kmem_wdata = '{period: val_q, elapsed: kent.elapsed};
        end else begin
          tmem_we      = 1'b1;
          tmem_wdata   = '{count: val_q, timeout: val_q};
          ten_d[taddr] = 1'b1;
        end
        state_d = tts_pkg::S_DONE;
      end

      tts_pkg::S_DONE: begin
        // hold the result until the output register frees
        if (out_free) begin
          out_load    = 1'b1;
          out_valid_d = 1'b1;
          state_d     = tts_pkg::S_IDLE;
        end
      end

      default: state_d = tts_pkg::S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= tts_pkg::S_IDLE;
      ten_q       <= '0;
      ken_q       <= '0;
      out_valid_q <= 1'b0;
      idx_q       <= '0;
    end else begin
      state_q     <= state_d;
      ten_q       <= ten_d;
      ken_q       <= ken_d;
      out_valid_q <= out_valid_d;
      idx_q       <= idx_d;
    end
  end

  always_ff @(posedge clk_i) begin
    func_q   <= func_d;
    id_q     <= id_d;
    val_q    <= val_d;
    status_q <= status_d;
    tfired_q <= tfired_d;
    kfired_q <= kfired_d;
    count_q  <= count_d;
    if (out_load) begin
      out_status_q <= status_q;
      out_tfired_q <= tfired_q;
      out_kfired_q <= kfired_q;
      out_count_q  <= count_q;
    end
  end

  assign out_valid_o   = out_valid_q;
  assign status_o      = out_status_q;
  assign timer_fired_o = out_tfired_q;
  assign task_fired_o  = out_kfired_q;
  assign timer_count_o = out_count_q;

  // --------------------------------------------------------------------------
  // Assertions
  // --------------------------------------------------------------------------
  a_status_code: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (status_o == tts_pkg::ST_OK || status_o == tts_pkg::ST_BAD_ID ||
                     status_o == tts_pkg::ST_BAD_VALUE))
    else $error("result carries an undefined status code");

  a_fired_only_ok: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && (timer_fired_o != '0 || task_fired_o != '0))
      |-> (status_o == tts_pkg::ST_OK && timer_count_o == '0))
    else $error("fired bits alongside an error status or a count");

  a_div_value_cmd: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == tts_pkg::S_DIV)
      |-> (func_q == tts_pkg::FN_SET_PERIOD || func_q == tts_pkg::FN_RELOAD))
    else $error("remainder unit busy for a command without a value");

  a_result_from_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> $past(state_q == tts_pkg::S_DONE))
    else $error("result raised outside the done step");

  a_no_write_while_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == tts_pkg::S_IDLE) |-> !(tmem_we || kmem_we))
    else $error("memory written while idle");

endmodule

`default_nettype wire

// ----- sim/tts_checker.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tts_checker: result checker of the tick scheduler
// Keeps its own copy of the timer and task tables, follows the APB register
// writes and each accepted command item, and compares every result item
// field by field with the oldest outstanding prediction.
// ----------------------------------------------------------------------------
module tts_checker #(
  parameter int unsigned MAX_TIMERS = tts_pkg::MaxTimersDef,
  parameter int unsigned MAX_TASKS  = tts_pkg::MaxTasksDef
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  // configuration port
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [3:0]        paddr,
  input  logic [31:0]       pwdata,
  input  logic              pready,
  // command channel
  input  logic              in_valid_i,
  input  logic              in_ready_i,
  input  logic [2:0]        func_i,
  input  logic [2:0]        index_i,
  input  logic [31:0]       new_value_i,
  // result channel
  input  logic              out_valid_i,
  input  logic              out_ready_i,
  input  logic [1:0]        status_i,
  input  logic [7:0]        timer_fired_i,
  input  logic [7:0]        task_fired_i,
  input  logic [31:0]       timer_count_i,
  // tallies for the test top
  output int unsigned       fail_count_o,
  output int unsigned       outstanding_o,
  output int unsigned       checked_o,
  output int unsigned       timer_hits_o,
  output int unsigned       task_hits_o,
  output int unsigned       rejects_o
);

  typedef struct packed {
    tts_pkg::func_e   op;
    logic [2:0]       idx;
    tts_pkg::status_e status;
    logic [7:0]       tfired;
    logic [7:0]       kfired;
    logic [31:0]      count;
  } sched_result_t;

  localparam int unsigned PrintCap = 100;

  // configuration mirror
  logic [15:0] tick_step;
  logic [3:0]  timers_in_use;
  logic [3:0]  tasks_in_use;

  // table mirror
  logic [31:0] tmr_count   [MAX_TIMERS];
  logic [31:0] tmr_timeout [MAX_TIMERS];
  logic        tmr_on      [MAX_TIMERS];
  logic [31:0] task_period [MAX_TASKS];
  logic [31:0] task_elapsed[MAX_TASKS];
  logic        task_on     [MAX_TASKS];

  sched_result_t pending_results[$];

  task automatic log_mismatch(input string msg);
    if (fail_count_o < PrintCap) begin
      $display("[%0t] MISMATCH %s", $realtime, msg);
    end
    fail_count_o++;
  endtask

  // Apply one command to the mirror and return the result it should give.
  function automatic sched_result_t schedule_outcome(input tts_pkg::func_e op,
                                                     input logic [2:0] idx,
                                                     input logic [31:0] value);
    sched_result_t res;
    int unsigned   live_timers;
    int unsigned   live_tasks;
    int unsigned   i;
    logic          id_ok;
    logic          value_ok;
    logic [31:0]   step32;
    res        = '0;
    res.op     = op;
    res.idx    = idx;
    res.status = tts_pkg::ST_OK;
    step32      = {16'h0, tick_step};
    live_timers = (timers_in_use < MAX_TIMERS) ? timers_in_use : MAX_TIMERS;
    live_tasks  = (tasks_in_use < MAX_TASKS) ? tasks_in_use : MAX_TASKS;
    if (op == tts_pkg::FN_TICK) begin
      for (i = 0; i < live_timers; i++) begin
        if (tmr_on[i]) begin
          tmr_count[i] = tmr_count[i] - step32;
          if (tmr_count[i] == '0 && i < tts_pkg::FiredBits) res.tfired[i] = 1'b1;
        end
      end
      for (i = 0; i < live_tasks; i++) begin
        if (task_on[i]) begin
          task_elapsed[i] = task_elapsed[i] + step32;
          if (task_elapsed[i] >= task_period[i]) begin
            if (i < tts_pkg::FiredBits) res.kfired[i] = 1'b1;
            task_elapsed[i] = '0;
          end
        end
      end
    end else begin
      if (op == tts_pkg::FN_START_TASK || op == tts_pkg::FN_STOP_TASK ||
          op == tts_pkg::FN_SET_PERIOD)
        id_ok = idx < live_tasks;
      else
        id_ok = idx < live_timers;
      // a zero step lets every value through
      value_ok = (value >= step32) && (tick_step == '0 || (value % step32) == '0);
      if (!id_ok) begin
        res.status = tts_pkg::ST_BAD_ID;
      end else if ((op == tts_pkg::FN_SET_PERIOD || op == tts_pkg::FN_RELOAD) &&
                   !value_ok) begin
        res.status = tts_pkg::ST_BAD_VALUE;
      end else begin
        case (op)
          tts_pkg::FN_START_TASK: task_on[idx] = 1'b1;
          tts_pkg::FN_STOP_TASK:  task_on[idx] = 1'b0;
          tts_pkg::FN_SET_PERIOD: task_period[idx] = value;
          tts_pkg::FN_RELOAD: begin
            tmr_timeout[idx] = value;
            tmr_count[idx]   = value;
            tmr_on[idx]      = 1'b1;
          end
          tts_pkg::FN_START_TIMER: begin
            tmr_on[idx] = 1'b1;
            if (tmr_count[idx] == '0) tmr_count[idx] = tmr_timeout[idx];
          end
          tts_pkg::FN_STOP_TIMER: tmr_on[idx] = 1'b0;
          tts_pkg::FN_READ_TIMER: res.count = tmr_count[idx];
          default: ;
        endcase
      end
    end
    return res;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    sched_result_t want;
    if (!rst_ni) begin
      tick_step     = tts_pkg::TickStepRst;
      timers_in_use = tts_pkg::TimersInUseRst;
      tasks_in_use  = tts_pkg::TasksInUseRst;
      for (int i = 0; i < MAX_TIMERS; i++) begin
        tmr_count[i]   = '0;
        tmr_timeout[i] = '0;
        tmr_on[i]      = 1'b0;
      end
      for (int i = 0; i < MAX_TASKS; i++) begin
        task_period[i]  = '0;
        task_elapsed[i] = '0;
        task_on[i]      = 1'b0;
      end
      pending_results.delete();
      fail_count_o  = 0;
      outstanding_o = 0;
      checked_o     = 0;
      timer_hits_o  = 0;
      task_hits_o   = 0;
      rejects_o     = 0;
    end else begin
      if (psel && penable && pwrite && pready) begin
        case (paddr[3:2])
          tts_pkg::RegTickStep:    tick_step     = pwdata[15:0];
          tts_pkg::RegTimersInUse: timers_in_use = pwdata[3:0];
          tts_pkg::RegTasksInUse:  tasks_in_use  = pwdata[3:0];
          default: ;
        endcase
      end
      if (out_valid_i && out_ready_i) begin
        if (pending_results.size() == 0) begin
          log_mismatch("result item with nothing outstanding");
        end else begin
          want = pending_results.pop_front();
          checked_o++;
          timer_hits_o += $countones(want.tfired);
          task_hits_o  += $countones(want.kfired);
          if (want.status != tts_pkg::ST_OK) rejects_o++;
          if (status_i !== want.status)
            log_mismatch($sformatf("%s[%0d] status: got %0d, want %0d",
                                   want.op.name(), want.idx, status_i, want.status));
          if (timer_fired_i !== want.tfired)
            log_mismatch($sformatf("%s[%0d] timer_fired: got %02h, want %02h",
                                   want.op.name(), want.idx, timer_fired_i, want.tfired));
          if (task_fired_i !== want.kfired)
            log_mismatch($sformatf("%s[%0d] task_fired: got %02h, want %02h",
                                   want.op.name(), want.idx, task_fired_i, want.kfired));
          if (timer_count_i !== want.count)
            log_mismatch($sformatf("%s[%0d] timer_count: got %08h, want %08h",
                                   want.op.name(), want.idx, timer_count_i, want.count));
        end
      end
      if (in_valid_i && in_ready_i) begin
        pending_results.push_back(schedule_outcome(tts_pkg::func_e'(func_i), index_i,
                                                   new_value_i));
      end
      outstanding_o = pending_results.size();
    end
  end

endmodule

// ----- sim/tick_task_and_timer_scheduler_top_test.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tick_task_and_timer_scheduler_top_test: test top of the tick scheduler
// Drives a directed run through ticks, timer and task commands, bad ids and
// bad values, then phases of random commands under varied register
// settings with random idling on both channels; the checker gives the count.
// ----------------------------------------------------------------------------
module tick_task_and_timer_scheduler_top_test;

  localparam int unsigned Phases        = 11;
  localparam int unsigned PhaseItems    = 112;
  localparam int unsigned SettleCycles  = 40;
  localparam int unsigned HoldCycles    = 300;
  localparam int unsigned CycleLimit    = 600000;

  logic        clk_i       = 1'b0;
  logic        rst_ni      = 1'b0;
  logic        psel        = 1'b0;
  logic        penable     = 1'b0;
  logic        pwrite      = 1'b0;
  logic [3:0]  paddr       = '0;
  logic [31:0] pwdata      = '0;
  logic [31:0] prdata;
  logic        pready;
  logic        in_valid_i  = 1'b0;
  logic        in_ready_o;
  logic [2:0]  func_i      = '0;
  logic [2:0]  index_i     = '0;
  logic [31:0] new_value_i = '0;
  logic        out_valid_o;
  logic        out_ready_i = 1'b0;
  logic [1:0]  status_o;
  logic [7:0]  timer_fired_o;
  logic [7:0]  task_fired_o;
  logic [31:0] timer_count_o;

  int unsigned mismatches;
  int unsigned outstanding;
  int unsigned checked;
  int unsigned timer_hits;
  int unsigned task_hits;
  int unsigned rejects;

  int unsigned cycle_cnt     = 0;
  int unsigned items_sent    = 0;
  int unsigned settings_used = 1;
  int unsigned idle_odds     = 0;
  logic        hold_req      = 1'b0;
  logic [15:0] cur_step      = tts_pkg::TickStepRst;

  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  always @(posedge clk_i) cycle_cnt <= cycle_cnt + 1;

  tick_task_and_timer_scheduler_top DUT (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .psel         (psel),
    .penable      (penable),
    .pwrite       (pwrite),
    .paddr        (paddr),
    .pwdata       (pwdata),
    .prdata       (prdata),
    .pready       (pready),
    .in_valid_i   (in_valid_i),
    .in_ready_o   (in_ready_o),
    .func_i       (func_i),
    .index_i      (index_i),
    .new_value_i  (new_value_i),
    .out_valid_o  (out_valid_o),
    .out_ready_i  (out_ready_i),
    .status_o     (status_o),
    .timer_fired_o(timer_fired_o),
    .task_fired_o (task_fired_o),
    .timer_count_o(timer_count_o)
  );

  tts_checker u_checker (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .psel         (psel),
    .penable      (penable),
    .pwrite       (pwrite),
    .paddr        (paddr),
    .pwdata       (pwdata),
    .pready       (pready),
    .in_valid_i   (in_valid_i),
    .in_ready_i   (in_ready_o),
    .func_i       (func_i),
    .index_i      (index_i),
    .new_value_i  (new_value_i),
    .out_valid_i  (out_valid_o),
    .out_ready_i  (out_ready_i),
    .status_i     (status_o),
    .timer_fired_i(timer_fired_o),
    .task_fired_i (task_fired_o),
    .timer_count_i(timer_count_o),
    .fail_count_o (mismatches),
    .outstanding_o(outstanding),
    .checked_o    (checked),
    .timer_hits_o (timer_hits),
    .task_hits_o  (task_hits),
    .rejects_o    (rejects)
  );

  // Offer one command item and hold it until it is taken; maybe idle after.
  task automatic issue(input tts_pkg::func_e op, input logic [2:0] idx,
                       input logic [31:0] value);
    in_valid_i  <= 1'b1;
    func_i      <= op;
    index_i     <= idx;
    new_value_i <= value;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
    items_sent++;
    if (idle_odds != 0 && $urandom_range(1, idle_odds) == 1) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 17)) @(posedge clk_i);
    end
  endtask

  // Drop valid and wait until every result is back and the block is quiet.
  task automatic drain();
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    wait (outstanding == 0);
    repeat (SettleCycles) @(posedge clk_i);
  endtask

  task automatic write_reg(input logic [1:0] reg_idx, input logic [31:0] value);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {reg_idx, 2'b00};
    pwdata  <= value;
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    while (!pready) @(posedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  task automatic program_scheduler(input logic [15:0] step, input logic [3:0] n_timers,
                                   input logic [3:0] n_tasks);
    drain();
    write_reg(tts_pkg::RegTickStep, {16'h0, step});
    write_reg(tts_pkg::RegTimersInUse, {28'h0, n_timers});
    write_reg(tts_pkg::RegTasksInUse, {28'h0, n_tasks});
    cur_step = step;
    settings_used++;
  endtask

  // Mostly well-formed values (small multiples of the step) so that timers
  // and tasks actually expire; the rest are zero, off-step or fully random.
  task automatic run_random(input int unsigned n_items);
    tts_pkg::func_e op;
    logic [31:0]    value;
    int unsigned    pick;
    repeat (n_items) begin
      if ($urandom_range(0, 99) < 35) op = tts_pkg::FN_TICK;
      else op = tts_pkg::func_e'($urandom_range(1, 7));
      pick = $urandom_range(0, 99);
      if (op != tts_pkg::FN_SET_PERIOD && op != tts_pkg::FN_RELOAD) value = $urandom();
      else if (pick < 65) value = $urandom_range(1, 12) * cur_step;
      else if (pick < 75) value = '0;
      else if (pick < 88) value = $urandom_range(1, 12) * cur_step + $urandom_range(1, 3);
      else value = $urandom();
      issue(op, 3'($urandom_range(0, 7)), value);
    end
  endtask

  // Result side: random stall bursts, plus one long hold-off on request.
  initial begin : result_sink
    forever begin
      @(posedge clk_i);
      if (hold_req) begin
        out_ready_i <= 1'b0;
        repeat (HoldCycles) @(posedge clk_i);
        hold_req = 1'b0;
        out_ready_i <= 1'b1;
      end else if (idle_odds != 0 && $urandom_range(1, 2 * idle_odds) == 1) begin
        out_ready_i <= 1'b0;
        repeat ($urandom_range(1, 17)) @(posedge clk_i);
        out_ready_i <= 1'b1;
      end else begin
        out_ready_i <= 1'b1;
      end
    end
  end

  initial begin : watchdog
    wait (cycle_cnt >= CycleLimit);
    $display("Timed out after %0d cycles, %0d results outstanding", cycle_cnt, outstanding);
    $display("== FAIL ==");
    $finish;
  end

  initial begin : stimulus
    int unsigned ph;
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    idle_odds = 8;

    // reset settings: untouched counts, zero timeout, zero period, wrap
    issue(tts_pkg::FN_READ_TIMER, 3'd0, 32'h0);
    issue(tts_pkg::FN_START_TIMER, 3'd0, 32'h0);
    issue(tts_pkg::FN_START_TASK, 3'd0, 32'h0);
    issue(tts_pkg::FN_RELOAD, 3'd7, 32'd3);
    issue(tts_pkg::FN_RELOAD, 3'd1, 32'h0);
    issue(tts_pkg::FN_SET_PERIOD, 3'd6, 32'hFFFF_FFFF);
    issue(tts_pkg::FN_START_TASK, 3'd6, 32'h0);
    issue(tts_pkg::FN_SET_PERIOD, 3'd5, 32'd2);
    issue(tts_pkg::FN_START_TASK, 3'd5, 32'h0);
    repeat (4) issue(tts_pkg::FN_TICK, 3'd0, 32'h0);
    issue(tts_pkg::FN_READ_TIMER, 3'd7, 32'h0);
    issue(tts_pkg::FN_STOP_TIMER, 3'd0, 32'h0);
    issue(tts_pkg::FN_STOP_TASK, 3'd2, 32'h0);

    // narrow tables: bad id beats bad value, an off-step and an on-step value
    program_scheduler(16'd4, 4'd2, 4'd3);
    issue(tts_pkg::FN_START_TASK, 3'd5, 32'h0);
    issue(tts_pkg::FN_RELOAD, 3'd3, 32'd5);
    issue(tts_pkg::FN_RELOAD, 3'd1, 32'd6);
    issue(tts_pkg::FN_RELOAD, 3'd1, 32'd4);
    issue(tts_pkg::FN_TICK, 3'd0, 32'h0);

    // zero step and no timers in use
    program_scheduler(16'd0, 4'd0, 4'd15);
    issue(tts_pkg::FN_START_TIMER, 3'd0, 32'h0);
    issue(tts_pkg::FN_SET_PERIOD, 3'd2, 32'h0);
    issue(tts_pkg::FN_START_TASK, 3'd2, 32'h0);
    issue(tts_pkg::FN_TICK, 3'd0, 32'h0);
    issue(tts_pkg::FN_READ_TIMER, 3'd7, 32'h0);

    for (ph = 0; ph < Phases; ph++) begin
      case (ph)
        0: program_scheduler(16'd1, 4'd8, 4'd8);
        1: program_scheduler(16'hFFFF, 4'd8, 4'd8);
        2: program_scheduler(16'd0, 4'd15, 4'd0);
        3: program_scheduler(16'd3, 4'd1, 4'd15);
        4: program_scheduler(16'd4, 4'd5, 4'd3);
        Phases - 1: program_scheduler(16'd2, 4'd8, 4'd8);
        default: begin
          program_scheduler(($urandom_range(0, 3) == 0) ? 16'($urandom_range(17, 65535))
                                                        : 16'($urandom_range(1, 16)),
                            4'($urandom_range(0, 15)), 4'($urandom_range(0, 15)));
        end
      endcase
      case ($urandom_range(0, 2))
        0: idle_odds = 0;
        1: idle_odds = 3;
        default: idle_odds = 8;
      endcase
      // closing phase runs flat out on both sides
      if (ph == Phases - 1) idle_odds = 0;
      // long receiver hold-off while commands keep coming
      if (ph == 1) hold_req = 1'b1;
      run_random(PhaseItems);
    end

    drain();
    $display("Sent %0d command items under %0d register settings, %0d results checked",
             items_sent, settings_used, checked);
    $display("Saw %0d timer expiries, %0d task expiries and %0d rejected commands",
             timer_hits, task_hits, rejects);
    if (mismatches == 0 && outstanding == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule

// ----- tick_task_and_timer_scheduler_top.f -----
design/tts_pkg.sv
design/tts_rem.sv
design/tick_task_and_timer_scheduler_top.sv
sim/tts_checker.sv
sim/tick_task_and_timer_scheduler_top_test.sv
